### hdl/dsa_pkg.sv
`timescale 1ns / 1ps
package dsa_pkg;
  localparam int MaxDigits = 128;
  localparam int AddrW = $clog2(MaxDigits);
  localparam int CountW = $clog2(MaxDigits + 1);
  localparam int PosW = $clog2(2 * MaxDigits + 2);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic       is_digit;
    logic       is_point;
    logic [3:0] digit;
  } cmd_t;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharPoint = 8'h2e;
endpackage

### hdl/dsa_ram.sv
`timescale 1ns / 1ps
module dsa_ram #(
  parameter int Width = 4,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/dsa_front.sv
`timescale 1ns / 1ps
module dsa_front import dsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  logic [7:0] text_char,
  input  logic       q_full,
  output logic       busy,
  output logic       push,
  output cmd_t       push_cmd
);
  always_comb begin
    busy = q_full;
    push = start && !q_full && (op != OP_NONE);
    push_cmd.op = op;
    push_cmd.is_point = (text_char == CharPoint);
    push_cmd.is_digit = (text_char >= CharZero) && (text_char <= CharZero + 8'd9);
    push_cmd.digit = 4'(text_char - CharZero);
  end
  logic unused;
  assign unused = clk ^ rst;
endmodule

### hdl/dsa_queue.sv
`timescale 1ns / 1ps
module dsa_queue import dsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic avail,
  output cmd_t head
);
  cmd_t slot [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slot[wp] <= push_cmd;
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### hdl/dsa_back.sv
`timescale 1ns / 1ps
module dsa_back import dsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  cmd_t       head,
  output logic       pop,
  output logic       done,
  output logic [7:0] sum_char,
  output logic       last,
  output logic       truncated
);
  typedef enum logic [2:0] {
    S_IDLE, S_FRAC, S_INT, S_SHIFT, S_READ, S_OUT
  } state_t;

  state_t state;
  logic [CountW-1:0] a_int_count, a_frac_count, b_int_count, b_frac_count;
  logic a_point_seen, b_point_seen, overflow_seen, sum_ready, carry;
  logic [CountW-1:0] idx;
  logic [CountW:0] sum_int_count;
  logic [PosW-1:0] read_position;
  logic stage;

  logic ai_we, af_we, bi_we, bf_we, si_we, sf_we;
  logic [AddrW-1:0] ai_wa, af_wa, bi_wa, bf_wa, sf_wa, ai_ra, af_ra, bi_ra, bf_ra, sf_ra;
  logic [AddrW:0] si_wa, si_ra;
  logic [3:0] ai_rd, af_rd, bi_rd, bf_rd, si_rd, sf_rd, si_wd, sf_wd;

  dsa_ram #(.Width(4), .Depth(MaxDigits)) u_ai (.clk, .we(ai_we), .waddr(ai_wa),
    .wdata(head.digit), .raddr(ai_ra), .rdata(ai_rd));
  dsa_ram #(.Width(4), .Depth(MaxDigits)) u_af (.clk, .we(af_we), .waddr(af_wa),
    .wdata(head.digit), .raddr(af_ra), .rdata(af_rd));
  dsa_ram #(.Width(4), .Depth(MaxDigits)) u_bi (.clk, .we(bi_we), .waddr(bi_wa),
    .wdata(head.digit), .raddr(bi_ra), .rdata(bi_rd));
  dsa_ram #(.Width(4), .Depth(MaxDigits)) u_bf (.clk, .we(bf_we), .waddr(bf_wa),
    .wdata(head.digit), .raddr(bf_ra), .rdata(bf_rd));
  dsa_ram #(.Width(4), .Depth(2 * MaxDigits)) u_si (.clk, .we(si_we), .waddr(si_wa),
    .wdata(si_wd), .raddr(si_ra), .rdata(si_rd));
  dsa_ram #(.Width(4), .Depth(MaxDigits)) u_sf (.clk, .we(sf_we), .waddr(sf_wa),
    .wdata(sf_wd), .raddr(sf_ra), .rdata(sf_rd));

  logic [CountW-1:0] flen, ilen;
  logic [4:0] dsum;
  logic a_in, b_in;
  logic is_load;

  assign flen = (a_frac_count > b_frac_count) ? a_frac_count : b_frac_count;
  assign ilen = (a_int_count > b_int_count) ? a_int_count : b_int_count;
  assign is_load = (head.op == OP_LOAD_A) || (head.op == OP_LOAD_B);

  // Digit index idx runs downward for the fraction and upward (from the ones digit) for the integer part.
  always_comb begin
    ai_ra = AddrW'(a_int_count - 1'b1 - idx);
    bi_ra = AddrW'(b_int_count - 1'b1 - idx);
    af_ra = AddrW'(idx);
    bf_ra = AddrW'(idx);
    if (state == S_FRAC) begin
      a_in = idx < a_frac_count;
      b_in = idx < b_frac_count;
      dsum = 5'(carry) + (a_in ? 5'(af_rd) : 5'd0) + (b_in ? 5'(bf_rd) : 5'd0);
    end else begin
      a_in = idx < a_int_count;
      b_in = idx < b_int_count;
      dsum = 5'(carry) + (a_in ? 5'(ai_rd) : 5'd0) + (b_in ? 5'(bi_rd) : 5'd0);
    end
    sf_wd = (dsum >= 5'd10) ? 4'(dsum - 5'd10) : dsum[3:0];
    si_wd = (state == S_SHIFT) ? 4'd1 : sf_wd;
    sf_wa = AddrW'(idx);
    si_wa = (AddrW+1)'(MaxDigits) + (AddrW+1)'(idx);
    sf_we = (state == S_FRAC) && stage;
    si_we = ((state == S_INT) && stage) || ((state == S_SHIFT) && carry);
    ai_we = (state == S_IDLE) && avail && (head.op == OP_LOAD_A) && !sum_ready &&
            head.is_digit && !a_point_seen && (a_int_count < CountW'(MaxDigits));
    bi_we = (state == S_IDLE) && avail && (head.op == OP_LOAD_B) && !sum_ready &&
            head.is_digit && !b_point_seen && (b_int_count < CountW'(MaxDigits));
    af_we = (state == S_IDLE) && avail && (head.op == OP_LOAD_A) && !sum_ready &&
            head.is_digit && a_point_seen && (a_frac_count < CountW'(MaxDigits));
    bf_we = (state == S_IDLE) && avail && (head.op == OP_LOAD_B) && !sum_ready &&
            head.is_digit && b_point_seen && (b_frac_count < CountW'(MaxDigits));
    ai_wa = AddrW'(a_int_count);
    bi_wa = AddrW'(b_int_count);
    af_wa = AddrW'(a_frac_count);
    bf_wa = AddrW'(b_frac_count);
    // Integer sum is stored reversed: ones digit at MaxDigits, leading 1 just above the top digit.
    si_ra = (AddrW+1)'(MaxDigits) + (AddrW+1)'(ilen) - 1'b1
            - (AddrW+1)'(read_position) + (AddrW+1)'(sum_int_count - (CountW+1)'(ilen));
    sf_ra = AddrW'(read_position - PosW'(sum_int_count) - 1'b1);
    pop = (state == S_IDLE) && avail && (is_load || sum_ready);
  end

  logic [PosW-1:0] total;
  assign total = PosW'(sum_int_count) + PosW'(flen) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a_int_count <= '0; a_frac_count <= '0; b_int_count <= '0; b_frac_count <= '0;
      a_point_seen <= 1'b0; b_point_seen <= 1'b0; overflow_seen <= 1'b0;
      sum_ready <= 1'b0; sum_int_count <= '0; read_position <= '0;
      carry <= 1'b0; idx <= '0; stage <= 1'b0; done <= 1'b0;
      sum_char <= '0; last <= 1'b0; truncated <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            if (is_load && !sum_ready) begin
              if (head.op == OP_LOAD_A) begin
                if (head.is_point) a_point_seen <= 1'b1;
                if (ai_we) a_int_count <= a_int_count + 1'b1;
                if (af_we) a_frac_count <= a_frac_count + 1'b1;
                if (head.is_digit && !ai_we && !af_we) overflow_seen <= 1'b1;
              end else begin
                if (head.is_point) b_point_seen <= 1'b1;
                if (bi_we) b_int_count <= b_int_count + 1'b1;
                if (bf_we) b_frac_count <= b_frac_count + 1'b1;
                if (head.is_digit && !bi_we && !bf_we) overflow_seen <= 1'b1;
              end
            end else if (head.op == OP_FETCH) begin
              if (sum_ready) begin
                state <= S_READ;
              end else begin
                carry <= 1'b0;
                stage <= 1'b0;
                idx <= (flen == '0) ? '0 : flen - 1'b1;
                state <= (flen == '0) ? S_INT : S_FRAC;
              end
            end
          end
        end
        S_FRAC: begin
          stage <= !stage;
          if (stage) begin
            carry <= dsum >= 5'd10;
            if (idx == '0) state <= S_INT;
            else idx <= idx - 1'b1;
          end
        end
        S_INT: begin
          if (idx == ilen) begin
            state <= S_SHIFT;
          end else begin
            stage <= !stage;
            if (stage) begin
              carry <= dsum >= 5'd10;
              idx <= idx + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          sum_int_count <= (CountW+1)'(ilen) + (CountW+1)'(carry);
          sum_ready <= 1'b1;
          read_position <= '0;
          state <= S_IDLE;
        end
        S_READ: state <= S_OUT;
        S_OUT: begin
          done <= 1'b1;
          truncated <= overflow_seen;
          last <= (read_position + 1'b1 >= total);
          if (read_position < PosW'(sum_int_count)) sum_char <= CharZero + 8'(si_rd);
          else if (read_position == PosW'(sum_int_count)) sum_char <= CharPoint;
          else sum_char <= CharZero + 8'(sf_rd);
          if (read_position + 1'b1 >= total) begin
            a_int_count <= '0; a_frac_count <= '0; b_int_count <= '0; b_frac_count <= '0;
            a_point_seen <= 1'b0; b_point_seen <= 1'b0; overflow_seen <= 1'b0;
            sum_ready <= 1'b0; sum_int_count <= '0; read_position <= '0;
          end else begin
            read_position <= read_position + 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/decimal_string_adder_core.sv
`timescale 1ns / 1ps
// Channel   Ports                              Handshake
// request   op, text_char                      start high and busy low
// result    sum_char, last, truncated          done strobe, one cycle
// A load pops in the idle state; a fetch of a computed sum passes the read and output states.
// The first fetch adds both operands first, over every digit position of the longer fraction
// and integer parts, then the final carry; each position waits for its registered store read.
// A two-entry request queue decouples intake from the back end; busy is queue full.
// The receiver cannot stall; only the request side waits on busy.
// Reset is synchronous and clears all counts; digit stores are not cleared.
module decimal_string_adder_core import dsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  logic [7:0] text_char,
  output logic       busy,
  output logic       done,
  output logic [7:0] sum_char,
  output logic       last,
  output logic       truncated
);
  logic q_full, push, pop, avail;
  cmd_t push_cmd, head;

  dsa_front u_front (.clk, .rst, .start, .op, .text_char, .q_full, .busy, .push, .push_cmd);
  dsa_queue u_queue (.clk, .rst, .push, .push_cmd, .pop, .full(q_full), .avail, .head);
  dsa_back u_back (.clk, .rst, .avail, .head, .pop, .done, .sum_char, .last, .truncated);

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push while queue full");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_last_point: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (sum_char != 8'h00))
    else $error("empty last char");
endmodule
